/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hle assertion failed");

`endif

/* rtl/hle_pkg.sv */
// Types, constants and register codes of the HSV to LED PWM encoder.
package hle_pkg;

    // Chain length; positions at or above it are dropped.
    localparam int LedCount = 256;
    // Duty codes emitted per LED (green, red, blue, 8 bits each).
    localparam int SlotsPerLed = 24;
    localparam int CntW = $clog2(SlotsPerLed);
    localparam logic [CntW-1:0] LastCnt = CntW'(SlotsPerLed - 1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_HIGH_DUTY = 2'd0,
        REG_LOW_DUTY  = 2'd1,
        REG_PREAMBLE  = 2'd2
    } t_hle_reg_idx;

    // Input request.
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic [7:0] led_position;
    } t_hle_in;

    // Output request.
    typedef struct packed {
        logic [12:0] slot_index;
        logic [7:0]  duty;
        logic        last_bit;
    } t_hle_out;

    // Configuration register file contents.
    typedef struct packed {
        logic [7:0] high_duty;
        logic [7:0] low_duty;
        logic [7:0] preamble_slots;
    } t_hle_cfg;

    // Converted pixel handed from the color pipeline to the serializer.
    typedef struct packed {
        logic [23:0] word;   // {green, red, blue}
        logic [7:0]  pos;
    } t_hle_pix;

    // Handshake between color pipeline and serializer.
    typedef struct packed {
        logic     valid;
        t_hle_pix pix;
    } t_hle_pix_req;

endpackage

/* rtl/hle_cfg_regs.sv */
// Configuration register file: duty codes and preamble length.
module hle_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output logic              o_cfg_ready,
    output hle_pkg::t_hle_cfg o_cfg
);
    import hle_pkg::*;

    t_hle_cfg r_cfg;
    t_hle_cfg n_cfg;

    // Decode the write; unknown indexes are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_hle_reg_idx'(i_cfg_index))
                REG_HIGH_DUTY: n_cfg.high_duty      = i_cfg_data;
                REG_LOW_DUTY:  n_cfg.low_duty       = i_cfg_data;
                REG_PREAMBLE:  n_cfg.preamble_slots = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_duty      <= 8'd60;
            r_cfg.low_duty       <= 8'd30;
            r_cfg.preamble_slots <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

/* rtl/hle_hsv_pipe.sv */
// Four-stage HSV to RGB pipeline (integer six-sector scheme).
module hle_hsv_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  hle_pkg::t_hle_in      i_data,
    output logic                  o_ready,
    output hle_pkg::t_hle_pix_req o_req,
    input  logic                  i_ready
);
    import hle_pkg::*;

    // Stage valids.
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    // Stage 1: sector, remainder, inverted saturation.
    logic [2:0] r_region1;
    logic [7:0] r_rem1, r_sinv1, r_s1, r_v1val, r_pos1;
    logic       r_grey1;
    // Stage 2: first products.
    logic [2:0] r_region2;
    logic [7:0] r_sr2, r_srn2, r_p2, r_vval2, r_pos2;
    logic       r_grey2;
    // Stage 3: q and t.
    logic [2:0] r_region3;
    logic [7:0] r_p3, r_q3, r_t3, r_vval3, r_pos3;
    logic       r_grey3;
    // Stage 4: packed GRB word.
    t_hle_pix   r_pix4;

    logic [2:0]  region;
    logic [5:0]  diff;
    logic [7:0]  rem;
    logic        pos_ok;
    logic [15:0] prod_sr, prod_srn, prod_p, prod_q, prod_t;
    logic [7:0]  r_c, g_c, b_c;

    // Backpressure chain, last stage first.
    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign pos_ok  = int'(i_data.led_position) < LedCount;

    // Sector by threshold compare, remainder scaled by six.
    always_comb begin
        if      (i_data.hue >= 8'd215) region = 3'd5;
        else if (i_data.hue >= 8'd172) region = 3'd4;
        else if (i_data.hue >= 8'd129) region = 3'd3;
        else if (i_data.hue >= 8'd86)  region = 3'd2;
        else if (i_data.hue >= 8'd43)  region = 3'd1;
        else                           region = 3'd0;
        diff = 6'(i_data.hue - 8'(region) * 8'd43);
        rem  = {diff, 2'b00} + {1'b0, diff, 1'b0};
    end

    // Multiplier stages.
    assign prod_sr  = r_s1 * r_rem1;
    assign prod_srn = r_s1 * (8'd255 - r_rem1);
    assign prod_p   = r_v1val * r_sinv1;
    assign prod_q   = r_vval2 * (8'd255 - r_sr2);
    assign prod_t   = r_vval2 * (8'd255 - r_srn2);

    // Sector select.
    always_comb begin
        case (r_region3)
            3'd0:    begin r_c = r_vval3; g_c = r_t3;    b_c = r_p3;    end
            3'd1:    begin r_c = r_q3;    g_c = r_vval3; b_c = r_p3;    end
            3'd2:    begin r_c = r_p3;    g_c = r_vval3; b_c = r_t3;    end
            3'd3:    begin r_c = r_p3;    g_c = r_q3;    b_c = r_vval3; end
            3'd4:    begin r_c = r_t3;    g_c = r_p3;    b_c = r_vval3; end
            default: begin r_c = r_vval3; g_c = r_p3;    b_c = r_q3;    end
        endcase
        if (r_grey3) begin
            r_c = r_vval3;
            g_c = r_vval3;
            b_c = r_vval3;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid && pos_ok;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_region1 <= region;
            r_rem1    <= rem;
            r_sinv1   <= 8'd255 - i_data.saturation;
            r_s1      <= i_data.saturation;
            r_v1val   <= i_data.brightness;
            r_pos1    <= i_data.led_position;
            r_grey1   <= (i_data.saturation == 8'd0);
        end
        if (adv2) begin
            r_region2 <= r_region1;
            r_sr2     <= prod_sr[15:8];
            r_srn2    <= prod_srn[15:8];
            r_p2      <= prod_p[15:8];
            r_vval2   <= r_v1val;
            r_pos2    <= r_pos1;
            r_grey2   <= r_grey1;
        end
        if (adv3) begin
            r_region3 <= r_region2;
            r_p3      <= r_p2;
            r_q3      <= prod_q[15:8];
            r_t3      <= prod_t[15:8];
            r_vval3   <= r_vval2;
            r_pos3    <= r_pos2;
            r_grey3   <= r_grey2;
        end
        if (adv4) begin
            r_pix4.word <= {g_c, r_c, b_c};
            r_pix4.pos  <= r_pos3;
        end
    end

    assign o_req.valid = r_v4;
    assign o_req.pix   = r_pix4;

endmodule

/* rtl/hle_serializer.sv */
// Serializer: one duty code per cycle while not stalled, from a 24-bit GRB word, MSB first.
module hle_serializer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hle_pkg::t_hle_cfg     i_cfg,
    input  hle_pkg::t_hle_pix_req i_req,
    output logic                  o_ready,
    output logic                  o_valid,
    output hle_pkg::t_hle_out     o_data,
    input  logic                  i_stall
);
    import hle_pkg::*;

    logic            r_busy;
    logic [23:0]     r_word;
    logic [12:0]     r_slot;
    logic [CntW-1:0] r_cnt;
    logic            r_out_valid;
    t_hle_out        r_out;

    logic            load_out;
    logic            last;
    logic            take;
    logic [12:0]     base;

    // Move the next code into the output register when it is free.
    assign load_out = r_busy && (!r_out_valid || !i_stall);
    assign last     = (r_cnt == LastCnt);
    assign take     = i_req.valid && (!r_busy || (load_out && last));
    assign o_ready  = !r_busy || (load_out && last);
    // First slot: preamble + position * 24.
    assign base = 13'(i_cfg.preamble_slots) + 13'({i_req.pix.pos, 4'b0000})
                + 13'({i_req.pix.pos, 3'b000});

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (load_out) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) r_busy <= 1'b0;
            end
        end
    end

    // Word shifter, slot counter and output payload.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.slot_index <= r_slot;
            r_out.duty       <= r_word[23] ? i_cfg.high_duty : i_cfg.low_duty;
            r_out.last_bit   <= last;
        end
        if (take) begin
            r_word <= i_req.pix.word;
            r_slot <= base;
        end else if (load_out) begin
            r_word <= {r_word[22:0], 1'b0};
            r_slot <= r_slot + 13'd1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* rtl/hsv_to_led_pwm_encoder_top.sv */
// Top level of the HSV to LED PWM duty-code encoder.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | sink      | i_in_valid/o_in_stall   | t_hle_in (hue, sat, value, pos)
//   out     | source    | o_out_valid/i_out_stall | t_hle_out (slot, duty, last)
//   cfg     | sink      | i_cfg_valid/o_cfg_ready | index 2b, data 8b
//
// Each pixel yields 24 codes, one per cycle while the output is not stalled, so the
// serializer sets the pixel rate; it takes the next pixel as it loads the last code.
// A request passes four color stages, the serializer load and its output register.
// Reset is synchronous, active low, and clears all valid and busy state.
// A stall on the output freezes the serializer and backs up through the pipeline.
module hsv_to_led_pwm_encoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  hle_pkg::t_hle_in  i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output hle_pkg::t_hle_out o_out_data,
    input  logic              i_out_stall,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output logic              o_cfg_ready
);
    import hle_pkg::*;

    t_hle_cfg     cfg;
    t_hle_pix_req pix_req;
    logic         pipe_ready;
    logic         ser_ready;

    // Configuration registers.
    hle_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // Color conversion pipeline.
    hle_hsv_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_ready (pipe_ready),
        .o_req   (pix_req),
        .i_ready (ser_ready)
    );

    // Duty-code serializer.
    hle_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (pix_req),
        .o_ready (ser_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    assign o_in_stall = !pipe_ready;

endmodule

/* rtl/hle_checker.sv */
// Port-level checker for the encoder top level, with its bind.
`include "assert_macros.svh"

module hle_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input hle_pkg::t_hle_out o_out_data,
    input logic              i_out_stall,
    input logic              o_cfg_ready
);
    import hle_pkg::*;

    logic out_acc;
    assign out_acc = o_out_valid && !i_out_stall;

    // A stalled output request holds.
    `HLE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // Codes of one LED come back to back.
    `HLE_ASSERT_NXT(a_burst, i_clk, i_rst_n, out_acc && !o_out_data.last_bit, o_out_valid)
    // Slots of one LED are consecutive.
    `HLE_ASSERT_NXT(a_slot_step, i_clk, i_rst_n, out_acc && !o_out_data.last_bit, o_out_data.slot_index == 13'($past(o_out_data.slot_index) + 13'd1))
    // Configuration writes are never refused.
    `HLE_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready)

endmodule

bind hsv_to_led_pwm_encoder_top hle_checker u_hle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall),
    .o_cfg_ready (o_cfg_ready)
);
